// ----- rtl/cqoc_pkg.sv -----
// Package: shared constants, control word types and the microcode table of the orbit counter.
package cqoc_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 28;
  localparam int PROD_W     = 2 * WORD_WIDTH;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = WORD_WIDTH;
  localparam int STEP_W     = 3;

  localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = LIMIT_W'(256);
  localparam logic [WORD_WIDTH-1:0] THRESHOLD_RESET = WORD_WIDTH'(600239927);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NORM_THRESHOLD  = CFG_IDX_W'(1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // Multiplier operand pairs (magnitudes of the z components)
  typedef enum logic [1:0] {
    MUL_AA,
    MUL_BB,
    MUL_AB
  } mul_sel_t;

  // Destination of the registered product, shifted and range checked
  typedef enum logic [2:0] {
    WB_NONE,
    WB_AA,
    WB_BB,
    WB_AB,
    WB_R2,
    WB_I2
  } wb_dst_t;

  typedef struct packed {
    logic     exit_chk;  // leave the loop when the count is reached or overflow is set
    mul_sel_t mul_sel;
    wb_dst_t  wb_dst;
    logic     upd_re;    // new real part into z
    logic     upd_im;    // new imaginary part into z
    logic     accum;     // sum the squares, compare and count
    logic     wrap;      // back to the head of the loop
  } ctrl_word_t;

  typedef struct packed {
    logic done;
    logic ov;
  } dp_status_t;

  localparam int UCODE_LEN = 8;

  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{exit_chk: 1'b0, mul_sel: MUL_AA, wb_dst: WB_NONE, upd_re: 1'b0,
          upd_im: 1'b0, accum: 1'b0, wrap: 1'b0};
    case (step)
      3'd0: begin
        w.exit_chk = 1'b1;
        w.mul_sel  = MUL_AA;
      end
      3'd1: begin
        w.wb_dst  = WB_AA;
        w.mul_sel = MUL_BB;
      end
      3'd2: begin
        w.wb_dst  = WB_BB;
        w.mul_sel = MUL_AB;
      end
      3'd3: begin
        w.wb_dst = WB_AB;
        w.upd_re = 1'b1;
      end
      3'd4: begin
        w.upd_im  = 1'b1;
        w.mul_sel = MUL_AA;
      end
      3'd5: begin
        w.wb_dst  = WB_R2;
        w.mul_sel = MUL_BB;
      end
      3'd6: begin
        w.wb_dst = WB_I2;
      end
      3'd7: begin
        w.accum = 1'b1;
        w.wrap  = 1'b1;
      end
      default: begin
        w.wrap = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/complex_quadratic_orbit_counter.sv -----
// Top level: microcoded orbit counter with configuration registers and result strobe.
// out_valid is registered from the exit check at step 0, after the loop passes have run:
// iteration_limit of them, or fewer once the arithmetic overflows (the overflowing pass included).
// One pixel at a time: a new start is taken only while idle, and the eight-step microcode
// loop runs around the single shared multiplier. The receiver cannot stall.
// Reset (synchronous, rst_n low): sequencer idle, limit 256, threshold sqrt(5) in Q4.28.
module complex_quadratic_orbit_counter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [cqoc_pkg::WORD_WIDTH-1:0] in_c_real,
  input  logic signed [cqoc_pkg::WORD_WIDTH-1:0] in_c_imag,
  output logic                                  out_valid,
  output logic [cqoc_pkg::LIMIT_W-1:0]          out_inside_count,
  output logic [cqoc_pkg::WORD_WIDTH-1:0]       out_final_norm,
  input  logic                                  cfg_we,
  input  logic [cqoc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cqoc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import cqoc_pkg::*;

  seq_state_t              state_r, state_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [LIMIT_W-1:0]      limit_r;
  logic [WORD_WIDTH-1:0]   thresh_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [LIMIT_W-1:0]      out_count_r;
  logic [WORD_WIDTH-1:0]   out_norm_r;

  logic                    accept;
  logic                    finish;
  ctrl_word_t              ucw;
  ctrl_word_t              ctrl;
  dp_status_t              dp_status;
  logic [LIMIT_W-1:0]      dp_count;
  logic [WORD_WIDTH-1:0]   dp_norm;

  // A start transfer is taken only while idle
  assign accept = start && (state_r == ST_IDLE);

  // Fetch the control word of the current step; drive a quiet word while idle
  assign ucw = ucode_rom(step_r);

  always_comb begin
    ctrl = ucw;
    if (state_r != ST_RUN) begin
      ctrl.wb_dst = WB_NONE;
      ctrl.upd_re = 1'b0;
      ctrl.upd_im = 1'b0;
      ctrl.accum  = 1'b0;
    end
  end

  // Conditional jump out of the loop: iteration count reached or overflow latched
  assign finish = (state_r == ST_RUN) && ucw.exit_chk && dp_status.done;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt     = ST_IDLE;
          step_nxt      = '0;
          out_valid_nxt = 1'b1;
        end else if (ucw.wrap) begin
          step_nxt = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the result at the exit for its single strobe cycle; it holds until the next exit
  always_ff @(posedge clk) begin
    if (finish) begin
      out_count_r <= dp_count;
      out_norm_r  <= dp_norm;
    end
  end

  // Configuration registers; the user must write only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      thresh_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ITERATION_LIMIT: limit_r  <= cfg_wdata[LIMIT_W-1:0];
        REG_NORM_THRESHOLD:  thresh_r <= cfg_wdata[WORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  cqoc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (accept),
    .c_real    (in_c_real),
    .c_imag    (in_c_imag),
    .ctrl      (ctrl),
    .limit     (limit_r),
    .threshold (thresh_r),
    .status    (dp_status),
    .count     (dp_count),
    .norm      (dp_norm)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_inside_count = out_count_r;
  assign out_final_norm   = out_norm_r;

endmodule

// ----- rtl/cqoc_datapath.sv -----
// Datapath: z registers, shared multiplier, range checks, norm and count accumulation.
module cqoc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clear,
  input  logic [cqoc_pkg::WORD_WIDTH-1:0]    c_real,
  input  logic [cqoc_pkg::WORD_WIDTH-1:0]    c_imag,
  input  cqoc_pkg::ctrl_word_t               ctrl,
  input  logic [cqoc_pkg::LIMIT_W-1:0]       limit,
  input  logic [cqoc_pkg::WORD_WIDTH-1:0]    threshold,
  output cqoc_pkg::dp_status_t               status,
  output logic [cqoc_pkg::LIMIT_W-1:0]       count,
  output logic [cqoc_pkg::WORD_WIDTH-1:0]    norm
);
  import cqoc_pkg::*;

  localparam int W = WORD_WIDTH;

  logic [W-1:0]       cr_r, ci_r;
  logic [W-1:0]       a_r, a_nxt, b_r, b_nxt;
  logic [W-1:0]       aa_r, bb_r, ab_r, r2_r, i2_r;
  logic [PROD_W-1:0]  p_r;
  logic               neg_r;
  logic               ov_r, ov_nxt;
  logic [W-1:0]       norm_r, norm_nxt;
  logic [LIMIT_W-1:0] count_r, count_nxt, iter_r, iter_nxt;

  logic [W-1:0]       mag_a, mag_b, op_x, op_y;
  logic [PROD_W-1:0]  sh_p;
  logic               wb_ov;
  logic [W+1:0]       nr_sum, ni_sum, ab_ext, sab;
  logic               nr_fits, ni_fits;
  logic [W:0]         sq_sum;

  assign mag_a = a_r[W-1] ? W'(-a_r) : a_r;
  assign mag_b = b_r[W-1] ? W'(-b_r) : b_r;

  always_comb begin
    case (ctrl.mul_sel)
      MUL_AA: begin
        op_x = mag_a;
        op_y = mag_a;
      end
      MUL_BB: begin
        op_x = mag_b;
        op_y = mag_b;
      end
      MUL_AB: begin
        op_x = mag_a;
        op_y = mag_b;
      end
      default: begin
        op_x = mag_a;
        op_y = mag_b;
      end
    endcase
  end

  // 2ab carries one fraction bit less; the norm squares (R2, I2) bound to the unsigned word, the rest to W-1 bits
  assign sh_p  = (ctrl.wb_dst == WB_AB) ? (p_r >> (FRAC_BITS - 1)) : (p_r >> FRAC_BITS);
  assign wb_ov = (ctrl.wb_dst == WB_R2 || ctrl.wb_dst == WB_I2) ?
                 (|sh_p[PROD_W-1:W]) : (|sh_p[PROD_W-1:W-1]);

  assign nr_sum  = {2'b00, aa_r} - {2'b00, bb_r} + {{2{cr_r[W-1]}}, cr_r};
  assign nr_fits = (nr_sum[W+1:W-1] == 3'b000) || (nr_sum[W+1:W-1] == 3'b111);
  assign ab_ext  = {2'b00, ab_r};
  assign sab     = neg_r ? -ab_ext : ab_ext;
  assign ni_sum  = sab + {{2{ci_r[W-1]}}, ci_r};
  assign ni_fits = (ni_sum[W+1:W-1] == 3'b000) || (ni_sum[W+1:W-1] == 3'b111);
  assign sq_sum  = {1'b0, r2_r} + {1'b0, i2_r};

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    ov_nxt    = ov_r;
    norm_nxt  = norm_r;
    count_nxt = count_r;
    iter_nxt  = iter_r;
    if (ctrl.wb_dst != WB_NONE && wb_ov) begin
      ov_nxt = 1'b1;
    end
    if (ctrl.upd_re) begin
      a_nxt = nr_sum[W-1:0];
      if (!nr_fits) begin
        ov_nxt = 1'b1;
      end
    end
    if (ctrl.upd_im) begin
      b_nxt = ni_sum[W-1:0];
      if (!ni_fits) begin
        ov_nxt = 1'b1;
      end
    end
    if (ctrl.accum) begin
      iter_nxt = iter_r + LIMIT_W'(1);
      if (sq_sum[W]) begin
        ov_nxt = 1'b1;
      end else if (!ov_r) begin
        norm_nxt = sq_sum[W-1:0];
        if (sq_sum[W-1:0] < threshold) begin
          count_nxt = count_r + LIMIT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      iter_r  <= '0;
      count_r <= '0;
      norm_r  <= '0;
    end else if (clear) begin
      ov_r    <= 1'b0;
      iter_r  <= '0;
      count_r <= '0;
      norm_r  <= '0;
    end else begin
      ov_r    <= ov_nxt;
      iter_r  <= iter_nxt;
      count_r <= count_nxt;
      norm_r  <= norm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(op_x) * PROD_W'(op_y);
    if (clear) begin
      cr_r <= c_real;
      ci_r <= c_imag;
      a_r  <= '0;
      b_r  <= '0;
    end else begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
    if (ctrl.upd_re) begin
      neg_r <= a_r[W-1] ^ b_r[W-1];
    end
    case (ctrl.wb_dst)
      WB_AA:   aa_r <= sh_p[W-1:0];
      WB_BB:   bb_r <= sh_p[W-1:0];
      WB_AB:   ab_r <= sh_p[W-1:0];
      WB_R2:   r2_r <= sh_p[W-1:0];
      WB_I2:   i2_r <= sh_p[W-1:0];
      default: ;
    endcase
  end

  assign status.done = (iter_r == limit) || ov_r;
  assign status.ov   = ov_r;
  assign count       = count_r;
  assign norm        = ov_r ? '1 : norm_r;

endmodule
